[rtl/core/rlrc_pkg.sv]
// Shared types, constants and helpers for the run list rectangle coalescer.
`timescale 1ns / 1ps
`default_nettype none
package rlrc_pkg;
   localparam int MaxOpenDefault = 32;

   localparam logic [1:0] MODE_ROW_BEGIN = 2'd0;
   localparam logic [1:0] MODE_RUN       = 2'd1;
   localparam logic [1:0] MODE_ROW_END   = 2'd2;
   localparam logic [1:0] MODE_FRAME_END = 2'd3;

   localparam logic KIND_COLOR = 1'b0;
   localparam logic KIND_RECT  = 1'b1;

   localparam logic CSR_X_OFFSET = 1'b0;
   localparam logic CSR_Y_OFFSET = 1'b1;

   localparam int ReqDataW = 56;
   localparam int RspDataW = 80;

   typedef struct packed {
      logic [9:0]  x0;
      logic [9:0]  x1;
      logic [15:0] color;
      logic [9:0]  y0;
   } rect_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic push;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pend_any;
      logic out_free;
   } status_type;

   // RGBA5551 to RGBA32, channels shifted left three, alpha opaque
   function automatic logic [31:0] to_rgba32(input logic [15:0] p);
      to_rgba32 = {p[15:11], 3'b000, p[10:6], 3'b000, p[5:1], 3'b000, 8'hFF};
   endfunction
endpackage
`default_nettype wire

[rtl/core/rlrc_ctrl.sv]
// Controller state machine: accepts items and sequences the drain of open rectangles.
`timescale 1ns / 1ps
`default_nettype none
module rlrc_ctrl
   import rlrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic [1:0] req_mode,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);
   localparam logic S_IDLE  = 1'b0;
   localparam logic S_DRAIN = 1'b1;

   logic state_ff, state_in;

   // take items only when no drain is running
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.push   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_mode == MODE_ROW_END || req_mode == MODE_FRAME_END) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (!status.pend_any) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else if (status.out_free) begin
               cmd.push = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

[rtl/core/rlrc_dp.sv]
// Datapath: rectangle stores, run matching, drain selection and the result register.
`timescale 1ns / 1ps
`default_nettype none
module rlrc_dp
   import rlrc_pkg::*;
#(
   parameter int MAX_OPEN = MaxOpenDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic                csr_addr,
   input  wire logic [9:0]          csr_wdata,
   input  wire logic [1:0]          req_mode,
   input  wire logic [ReqDataW-1:0] req_tdata,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [RspDataW-1:0]      rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);
   localparam int IW = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
   localparam int CW = $clog2(MAX_OPEN + 1);

   rect_type open_ff [MAX_OPEN];
   rect_type next_ff [MAX_OPEN];
   logic [CW-1:0]       open_count_ff, next_count_ff;
   logic [MAX_OPEN-1:0] consumed_ff, pend_ff;
   logic [9:0]  prev_x_ff, row_index_ff, x_off_ff, y_off_ff;
   logic [15:0] row_bg_ff, last_color_ff;
   logic        color_known_ff, overflow_ff, drain_frame_ff;
   logic        out_valid_ff, out_kind_ff, out_last_ff;
   logic [RspDataW-1:0] out_data_ff;

   // unpack request
   logic [9:0]  start_x, run_end_x;
   logic [15:0] oob_color, span_color;
   assign start_x    = req_tdata[9:0];
   assign oob_color  = req_tdata[25:10];
   assign run_end_x  = req_tdata[35:26];
   assign span_color = req_tdata[51:36];

   // valid entries of the open store
   logic [MAX_OPEN-1:0] open_valid;
   always_comb begin
      for (int o = 0; o < MAX_OPEN; o++) begin
         open_valid[o] = (CW'(o) < open_count_ff);
      end
   end

   // run classification against the tail and the open store
   logic [IW-1:0]       tail_idx, nc_idx, hit_idx;
   rect_type            tail_rect;
   logic                skip, merge, full, hit;
   logic [MAX_OPEN-1:0] hit_vec;
   assign tail_idx  = IW'(next_count_ff - CW'(1));
   assign nc_idx    = IW'(next_count_ff);
   assign tail_rect = next_ff[tail_idx];
   assign skip  = (span_color == 16'd0) || (span_color == row_bg_ff) ||
                  (run_end_x <= prev_x_ff);
   assign merge = (next_count_ff != '0) && (tail_rect.color == span_color) &&
                  (tail_rect.x1 == prev_x_ff);
   assign full  = (next_count_ff >= CW'(MAX_OPEN));
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int o = 0; o < MAX_OPEN; o++) begin
         hit_vec[o] = open_valid[o] && !consumed_ff[o] && (open_ff[o].x0 == prev_x_ff) &&
                      (open_ff[o].x1 == run_end_x) && (open_ff[o].color == span_color);
      end
      for (int o = MAX_OPEN - 1; o >= 0; o--) begin
         if (hit_vec[o]) begin
            hit     = 1'b1;
            hit_idx = IW'(o);
         end
      end
   end

   // drain selection: lowest pending entry
   logic [IW-1:0]       sel_idx;
   logic [MAX_OPEN-1:0] sel_bit;
   rect_type            sel_rect;
   logic                need_color;
   always_comb begin
      sel_idx = '0;
      for (int o = MAX_OPEN - 1; o >= 0; o--) begin
         if (pend_ff[o]) sel_idx = IW'(o);
      end
      sel_bit = '0;
      sel_bit[sel_idx] = 1'b1;
   end
   assign sel_rect   = open_ff[sel_idx];
   assign need_color = !color_known_ff || (sel_rect.color != last_color_ff);

   assign status = '{pend_any: (pend_ff != '0), out_free: (!out_valid_ff || rsp_tready)};

   logic [10:0] left, top, right, bottom;
   assign left   = 11'(x_off_ff) + 11'(sel_rect.x0);
   assign right  = 11'(x_off_ff) + 11'(sel_rect.x1);
   assign top    = 11'(y_off_ff) + 11'(sel_rect.y0);
   assign bottom = 11'(y_off_ff) + 11'(row_index_ff);

   logic req_run;
   assign req_run = cmd.accept && (req_mode == MODE_RUN);

   // rectangle stores
   always_ff @(posedge clock) begin
      if (req_run && !skip) begin
         if (merge) begin
            next_ff[tail_idx].x1 <= run_end_x;
         end else if (!full) begin
            if (hit) begin
               next_ff[nc_idx] <= open_ff[hit_idx];
            end else begin
               next_ff[nc_idx] <= '{x0: prev_x_ff, x1: run_end_x, color: span_color,
                                    y0: row_index_ff};
            end
         end
      end
      if (cmd.finish && !drain_frame_ff) begin
         for (int o = 0; o < MAX_OPEN; o++) begin
            open_ff[o] <= next_ff[o];
         end
      end
   end

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         open_count_ff  <= '0;
         next_count_ff  <= '0;
         consumed_ff    <= '0;
         pend_ff        <= '0;
         prev_x_ff      <= '0;
         row_index_ff   <= '0;
         row_bg_ff      <= '0;
         last_color_ff  <= '0;
         color_known_ff <= 1'b0;
         overflow_ff    <= 1'b0;
         drain_frame_ff <= 1'b0;
         x_off_ff       <= '0;
         y_off_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_X_OFFSET) x_off_ff <= csr_wdata;
            else if (csr_addr == CSR_Y_OFFSET) y_off_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            case (req_mode)
               MODE_ROW_BEGIN: begin
                  prev_x_ff     <= start_x;
                  row_bg_ff     <= oob_color;
                  next_count_ff <= '0;
                  consumed_ff   <= '0;
               end
               MODE_RUN: begin
                  prev_x_ff <= run_end_x;
                  if (!skip && !merge) begin
                     if (full) begin
                        overflow_ff <= 1'b1;
                     end else begin
                        next_count_ff <= next_count_ff + CW'(1);
                        if (hit) consumed_ff[hit_idx] <= 1'b1;
                     end
                  end
               end
               MODE_ROW_END: begin
                  pend_ff        <= open_valid & ~consumed_ff;
                  drain_frame_ff <= 1'b0;
               end
               default: begin
                  pend_ff        <= open_valid;
                  drain_frame_ff <= 1'b1;
               end
            endcase
         end
         if (cmd.push && need_color) begin
            last_color_ff  <= sel_rect.color;
            color_known_ff <= 1'b1;
         end else if (cmd.push) begin
            pend_ff <= pend_ff & ~sel_bit;
         end
         if (cmd.finish) begin
            next_count_ff <= '0;
            consumed_ff   <= '0;
            if (drain_frame_ff) begin
               open_count_ff  <= '0;
               row_index_ff   <= '0;
               color_known_ff <= 1'b0;
               overflow_ff    <= 1'b0;
            end else begin
               open_count_ff <= next_count_ff;
               row_index_ff  <= row_index_ff + 10'd1;
            end
         end
         // result register
         if (cmd.push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         if (need_color) begin
            out_kind_ff <= KIND_COLOR;
            out_last_ff <= 1'b0;
            out_data_ff <= {3'b000, overflow_ff, 44'd0, to_rgba32(sel_rect.color)};
         end else begin
            out_kind_ff <= KIND_RECT;
            out_last_ff <= ((pend_ff & ~sel_bit) == '0);
            out_data_ff <= {3'b000, overflow_ff, bottom, right, top, left,
                            to_rgba32(sel_rect.color)};
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

[rtl/core/run_list_rectangle_coalescer.sv]
// Top level of the run list rectangle coalescer.
//
// Input channel req_*: one item per transfer; req_tuser carries the mode (row begin,
// run, row end, frame end). Result channel rsp_*: fill commands, rsp_tuser is the
// command kind, rsp_tlast marks the last command caused by one input item.
// csr_*: write port for x offset (index 0) and y offset (index 1), idle time only.
// Runs are matched against all open rectangles by parallel comparators, so
// back-to-back runs transfer every cycle. Row end and frame end items enter a
// drain that emits one command per cycle from the open store while the result
// channel does not stall: the item is accepted, each set-colour or rectangle
// command is sent, and the row is closed.
// The result register lets a command wait while the drain prepares no further one;
// the drain stalls while a held result waits on rsp_tready; nothing is lost or repeated.
// Synchronous reset clears counts, row state, offsets and the result register;
// the rectangle stores need no clearing as only entries below their counts are read.
`timescale 1ns / 1ps
`default_nettype none
module run_list_rectangle_coalescer
   import rlrc_pkg::*;
#(
   parameter int MAX_OPEN = MaxOpenDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic                csr_addr,
   input  wire logic [9:0]          csr_wdata,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // [9:0] start_x, [25:10] oob_color, [35:26] run_end_x, [51:36] span color
   input  wire logic [ReqDataW-1:0] req_tdata,
   // [1:0] mode
   input  wire logic [1:0]          req_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // [31:0] fill_color_rgba, [42:32] rect_left, [53:43] rect_top,
   // [64:54] rect_right, [75:65] rect_bottom, [76] overflow
   output logic [RspDataW-1:0]      rsp_tdata,
   // [0] cmd_kind
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);
   cmd_type    cmd;
   status_type status;

   rlrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rlrc_dp #(.MAX_OPEN(MAX_OPEN)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_mode   (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire

[rtl/core/rlrc_checker.sv]
// Port-level checks for the run list rectangle coalescer and their binding.
`timescale 1ns / 1ps
`default_nettype none
module rlrc_checker
   import rlrc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tvalid,
   input wire logic                req_tready,
   input wire logic [1:0]          req_tuser,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [RspDataW-1:0] rsp_tdata,
   input wire logic                rsp_tuser,
   input wire logic                rsp_tlast
);
   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a set-colour command is never marked last, as its rectangle follows
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_COLOR |-> !rsp_tlast)
      else $error("set-colour command marked last");

   // a run transfer causes no result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_RUN && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after run transfer");

   // nothing is shown right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind run_list_rectangle_coalescer rlrc_checker u_rlrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the run list rectangle coalescer.
`timescale 1ns / 1ps
module tb_top;
   import rlrc_pkg::*;

   typedef struct packed {
      logic [1:0]  mode;
      logic [9:0]  start_x;
      logic [15:0] oob_color;
      logic [9:0]  run_end_x;
      logic [15:0] span_color;
   } item_t;

   typedef struct packed {
      logic        kind;
      logic [31:0] rgba;
      logic [10:0] left;
      logic [10:0] top;
      logic [10:0] right;
      logic [10:0] bottom;
      logic        ovf;
      logic        last;
   } cmd_t;

   typedef struct packed {
      logic [9:0]  x0;
      logic [9:0]  x1;
      logic [15:0] color;
      logic [9:0]  y0;
   } box_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_addr = 1'b0;
   logic [9:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   run_list_rectangle_coalescer u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [9:0]  p_xoff, p_yoff;
   box_t        p_open [32];
   box_t        p_next [32];
   int          p_open_n, p_next_n;
   logic [31:0] p_used;
   logic [9:0]  p_prev_x, p_row;
   logic [15:0] p_bg, p_last_col;
   logic        p_col_known, p_ovf;

   item_t pending_items[$];
   cmd_t  expected_cmds[$];
   int    fail_count = 0;
   bit    calm = 1'b0;
   bit    req_taken = 1'b0;

   function automatic logic [31:0] rgba_of(logic [15:0] p);
      return {p[15:11], 3'b0, p[10:6], 3'b0, p[5:1], 3'b0, 8'hFF};
   endfunction

   function automatic void push_cmd(logic kind, logic [15:0] col, logic [10:0] l,
                                    logic [10:0] t, logic [10:0] r, logic [10:0] b);
      cmd_t c;
      c = '{kind, rgba_of(col), l, t, r, b, p_ovf, 1'b0};
      expected_cmds.push_back(c);
   endfunction

   function automatic void emit_box(box_t bx, logic [9:0] y_end);
      if (!p_col_known || bx.color != p_last_col) begin
         push_cmd(KIND_COLOR, bx.color, '0, '0, '0, '0);
         p_last_col = bx.color;
         p_col_known = 1'b1;
      end
      push_cmd(KIND_RECT, bx.color, 11'(p_xoff) + 11'(bx.x0), 11'(p_yoff) + 11'(bx.y0),
               11'(p_xoff) + 11'(bx.x1), 11'(p_yoff) + 11'(y_end));
   endfunction

   function automatic void add_run(logic [9:0] xe, logic [15:0] col);
      logic [9:0] px;
      px = p_prev_x;
      p_prev_x = xe;
      if (col == 0 || col == p_bg || xe <= px) return;
      if (p_next_n > 0 && p_next[p_next_n-1].color == col && p_next[p_next_n-1].x1 == px) begin
         p_next[p_next_n-1].x1 = xe;
         return;
      end
      if (p_next_n >= 32) begin
         p_ovf = 1'b1;
         return;
      end
      for (int o = 0; o < p_open_n; o++) begin
         if (!p_used[o] && p_open[o].x0 == px && p_open[o].x1 == xe
             && p_open[o].color == col) begin
            p_used[o] = 1'b1;
            p_next[p_next_n] = p_open[o];
            p_next_n++;
            return;
         end
      end
      p_next[p_next_n] = '{px, xe, col, p_row};
      p_next_n++;
   endfunction

   // predict the commands one accepted item causes
   function automatic void predict_item(item_t it);
      int first;
      first = expected_cmds.size();
      case (it.mode)
         MODE_ROW_BEGIN: begin
            p_prev_x = it.start_x;
            p_bg = it.oob_color;
            p_next_n = 0;
            p_used = '0;
         end
         MODE_RUN: add_run(it.run_end_x, it.span_color);
         MODE_ROW_END: begin
            for (int o = 0; o < p_open_n; o++)
               if (!p_used[o]) emit_box(p_open[o], p_row);
            for (int i = 0; i < p_next_n; i++) p_open[i] = p_next[i];
            p_open_n = p_next_n;
            p_next_n = 0;
            p_used = '0;
            p_row = p_row + 10'd1;
         end
         default: begin
            for (int o = 0; o < p_open_n; o++) emit_box(p_open[o], p_row);
            p_open_n = 0;
            p_next_n = 0;
            p_used = '0;
            p_row = '0;
            p_col_known = 1'b0;
            p_ovf = 1'b0;
         end
      endcase
      if (expected_cmds.size() > first) expected_cmds[expected_cmds.size()-1].last = 1'b1;
   endfunction

   // note input transfers at the rising edge they happen on
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
   end

   // driver: present items at the falling edge, hold until transferred
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            item_t done;
            done = pending_items.pop_front();
            predict_item(done);
         end
         if ((!req_tvalid || req_taken) && pending_items.size() > 0
             && (calm || $urandom_range(99) >= 22)) begin
            item_t nx;
            nx = pending_items[0];
            req_tvalid <= 1'b1;
            req_tuser <= nx.mode;
            req_tdata <= {4'b0, nx.span_color, nx.run_end_x, nx.oob_color, nx.start_x};
         end else if (!req_tvalid || req_taken) begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= calm || $urandom_range(99) >= 22;
      end
   end

   // monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         cmd_t want;
         cmd_t got;
         got = '{rsp_tuser, rsp_tdata[31:0], rsp_tdata[42:32], rsp_tdata[53:43],
                 rsp_tdata[64:54], rsp_tdata[75:65], rsp_tdata[76], rsp_tlast};
         if (expected_cmds.size() == 0) begin
            $error("unexpected result transfer %h", got);
            fail_count++;
         end else begin
            want = expected_cmds.pop_front();
            if (got.kind != want.kind) begin
               $error("cmd_kind exp %0d got %0d", want.kind, got.kind); fail_count++;
            end
            if (got.rgba != want.rgba) begin
               $error("fill_color_rgba exp %h got %h", want.rgba, got.rgba); fail_count++;
            end
            if (got.left != want.left) begin
               $error("rect_left exp %0d got %0d", want.left, got.left); fail_count++;
            end
            if (got.top != want.top) begin
               $error("rect_top exp %0d got %0d", want.top, got.top); fail_count++;
            end
            if (got.right != want.right) begin
               $error("rect_right exp %0d got %0d", want.right, got.right); fail_count++;
            end
            if (got.bottom != want.bottom) begin
               $error("rect_bottom exp %0d got %0d", want.bottom, got.bottom); fail_count++;
            end
            if (got.ovf != want.ovf) begin
               $error("overflow exp %0d got %0d", want.ovf, got.ovf); fail_count++;
            end
            if (got.last != want.last) begin
               $error("last_result exp %0d got %0d", want.last, got.last); fail_count++;
            end
         end
      end
   end

   function automatic item_t mk(logic [1:0] m, logic [9:0] sx, logic [15:0] bg,
                                logic [9:0] xe, logic [15:0] col);
      return '{m, sx, bg, xe, col};
   endfunction

   // colors mostly from a small palette so merges and continuations happen
   function automatic logic [15:0] pick_color();
      logic [15:0] pal [4] = '{16'h0843, 16'hF801, 16'h07FE, 16'hFFFF};
      if ($urandom_range(9) == 0) return 16'($urandom);
      return pal[$urandom_range(3)];
   endfunction

   // one row of well-formed runs
   task automatic queue_row(int n_runs, logic [9:0] x_base);
      logic [9:0] x;
      x = x_base;
      pending_items.push_back(mk(MODE_ROW_BEGIN, x, 16'h0001, 10'($urandom), 16'($urandom)));
      for (int i = 0; i < n_runs; i++) begin
         x = x + 10'($urandom_range(1, 12));
         pending_items.push_back(mk(MODE_RUN, 10'($urandom), 16'($urandom), x, pick_color()));
      end
      pending_items.push_back(mk(MODE_ROW_END, 10'($urandom), 16'($urandom),
                                 10'($urandom), 16'($urandom)));
   endtask

   task automatic csr_write(logic idx, logic [9:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_X_OFFSET) p_xoff = val;
      else p_yoff = val;
   endtask

   // let everything queued drain before touching the offsets
   task automatic wait_idle();
      wait (pending_items.size() == 0 && expected_cmds.size() == 0);
      repeat (80) @(negedge clock);
   endtask

   initial begin
      int rows;
      p_xoff = '0; p_yoff = '0; p_open_n = 0; p_next_n = 0; p_used = '0;
      p_prev_x = '0; p_row = '0; p_bg = '0; p_last_col = '0;
      p_col_known = 1'b0; p_ovf = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_write(CSR_X_OFFSET, 10'd1023);
      csr_write(CSR_Y_OFFSET, 10'd1023);

      // directed: extremes, skips, repeated row begin, frame end mid-row
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd5, 16'hFFFF));
      pending_items.push_back(mk(MODE_ROW_END, 0, 0, 0, 0));
      pending_items.push_back(mk(MODE_ROW_BEGIN, 10'd0, 16'hFFFF, 0, 0));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd4, 16'h0000));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd9, 16'hFFFF));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd9, 16'h1234));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd3, 16'h1234));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd1023, 16'hAAAA));
      pending_items.push_back(mk(MODE_ROW_BEGIN, 10'd1023, 16'h5555, 0, 0));
      pending_items.push_back(mk(MODE_ROW_BEGIN, 10'd0, 16'h0001, 0, 0));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd1, 16'hFFFE));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd2, 16'hFFFE));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd1023, 16'h0002));
      pending_items.push_back(mk(MODE_ROW_END, 0, 0, 0, 0));
      pending_items.push_back(mk(MODE_ROW_BEGIN, 10'd0, 16'h0001, 0, 0));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd2, 16'hFFFE));
      pending_items.push_back(mk(MODE_ROW_END, 0, 0, 0, 0));
      pending_items.push_back(mk(MODE_ROW_BEGIN, 10'd0, 16'h0001, 0, 0));
      pending_items.push_back(mk(MODE_RUN, 0, 0, 10'd7, 16'h8001));
      pending_items.push_back(mk(MODE_FRAME_END, 0, 0, 0, 0));
      pending_items.push_back(mk(MODE_FRAME_END, 0, 0, 0, 0));
      wait_idle();

      // overflow: 40 alternating one-pixel runs in one row
      csr_write(CSR_X_OFFSET, 10'd0);
      csr_write(CSR_Y_OFFSET, 10'd0);
      pending_items.push_back(mk(MODE_ROW_BEGIN, 10'd0, 16'h0001, 0, 0));
      for (int i = 1; i <= 40; i++)
         pending_items.push_back(mk(MODE_RUN, 0, 0, 10'(i), (i % 2) ? 16'h0843 : 16'hF801));
      pending_items.push_back(mk(MODE_ROW_END, 0, 0, 0, 0));
      pending_items.push_back(mk(MODE_FRAME_END, 0, 0, 0, 0));
      wait_idle();

      // random phases with varied offsets; one long phase without idling
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(CSR_X_OFFSET, 10'($urandom));
         csr_write(CSR_Y_OFFSET, 10'($urandom));
         calm = (ph == 2);
         rows = 0;
         while (rows < 16) begin
            logic [9:0] xb;
            xb = 10'($urandom_range(0, 40));
            if ($urandom_range(4) != 0) xb = 10'd0;
            queue_row($urandom_range(0, 8), xb);
            rows++;
            if ($urandom_range(9) == 0)
               pending_items.push_back(mk(2'($urandom), 10'($urandom), 16'($urandom),
                                          10'($urandom), 16'($urandom)));
         end
         pending_items.push_back(mk(MODE_FRAME_END, 0, 0, 0, 0));
         wait_idle();
      end
      calm = 1'b0;

      if (fail_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top: errors");
      $finish;
   end
endmodule
